// ===== design/nhqpt_pkg.sv =====
// shared constants, codes and item types for the queue pair tracker
package nhqpt_pkg;

   // field widths
   localparam int PAGE_BITS  = 12;
   localparam int PTR_W      = 16;
   localparam int OPC_W      = 8;
   localparam int ADDR_W     = 32;
   localparam int STAT_W     = 16;
   localparam int CW_W       = 32;
   localparam int CODE_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [PTR_W-1:0] SQ_MASK_RESET = 16'd63;
   localparam logic [PTR_W-1:0] CQ_MASK_RESET = 16'd255;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SQ_MASK = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CQ_MASK = 1'd1;

   // status codes
   localparam logic [CODE_W-1:0] ST_DONE       = 2'd0;
   localparam logic [CODE_W-1:0] ST_FULL       = 2'd1;
   localparam logic [CODE_W-1:0] ST_MISALIGNED = 2'd2;
   localparam logic [CODE_W-1:0] ST_NOT_READY  = 2'd3;

   // item modes and result kinds
   localparam logic MODE_SUBMIT   = 1'b0;
   localparam logic MODE_COMPLETE = 1'b1;
   localparam logic KIND_SUBMIT   = 1'b0;
   localparam logic KIND_COMPLETE = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [OPC_W-1:0]  opcode;
      logic [ADDR_W-1:0] data_addr;
      logic [STAT_W-1:0] entry_status;
      logic [PTR_W-1:0]  entry_sq_head;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [CODE_W-1:0] status_code;
      logic [CW_W-1:0]   command_word0;
      logic [PTR_W-1:0]  sq_doorbell;
      logic [PTR_W-1:0]  cq_doorbell;
      logic [PTR_W-1:0]  cq_slot;
      logic              command_ok;
      logic [PTR_W-1:0]  sq_head_seen;
   } rsp_type;

   typedef struct packed {
      logic [PTR_W-1:0] sq_mask;
      logic [PTR_W-1:0] cq_mask;
   } csr_type;

endpackage

// ===== design/nhqpt_if.sv =====
// request and response channel interfaces of the queue pair tracker
interface nhqpt_req_if;
   logic                           valid;
   logic                           ready;
   logic                           mode;
   logic [nhqpt_pkg::OPC_W-1:0]    opcode;
   logic [nhqpt_pkg::ADDR_W-1:0]   data_addr;
   logic [nhqpt_pkg::STAT_W-1:0]   entry_status;
   logic [nhqpt_pkg::PTR_W-1:0]    entry_sq_head;

   modport source (output valid, mode, opcode, data_addr, entry_status, entry_sq_head,
                   input ready);
   modport sink   (input valid, mode, opcode, data_addr, entry_status, entry_sq_head,
                   output ready);
endinterface

interface nhqpt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic [nhqpt_pkg::CODE_W-1:0]   status_code;
   logic [nhqpt_pkg::CW_W-1:0]     command_word0;
   logic [nhqpt_pkg::PTR_W-1:0]    sq_doorbell;
   logic [nhqpt_pkg::PTR_W-1:0]    cq_doorbell;
   logic [nhqpt_pkg::PTR_W-1:0]    cq_slot;
   logic                           command_ok;
   logic [nhqpt_pkg::PTR_W-1:0]    sq_head_seen;

   modport source (output valid, kind, status_code, command_word0, sq_doorbell, cq_doorbell,
                   cq_slot, command_ok, sq_head_seen,
                   input ready);
   modport sink   (input valid, kind, status_code, command_word0, sq_doorbell, cq_doorbell,
                   cq_slot, command_ok, sq_head_seen,
                   output ready);
endinterface

// ===== design/nhqpt_csr.sv =====
// queue mask registers written through the plain csr port
module nhqpt_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [nhqpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nhqpt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output nhqpt_pkg::csr_type               csr_out
);

   nhqpt_pkg::csr_type csr_ff, csr_in;

   // register decode
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            nhqpt_pkg::CSR_SQ_MASK: csr_in.sq_mask = csr_wdata;
            nhqpt_pkg::CSR_CQ_MASK: csr_in.cq_mask = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.sq_mask <= nhqpt_pkg::SQ_MASK_RESET;
         csr_ff.cq_mask <= nhqpt_pkg::CQ_MASK_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr_out = csr_ff;

endmodule

// ===== design/nhqpt_in_reg.sv =====
// input register stage holding one request item
module nhqpt_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  nhqpt_pkg::req_type in_data,
   output logic               out_valid,
   input  logic               out_take,
   output nhqpt_pkg::req_type out_data
);

   logic               valid_ff;
   nhqpt_pkg::req_type data_ff;

   // free when empty or when the held item moves on this cycle
   assign in_ready = !valid_ff || out_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/nhqpt_core.sv =====
// queue pointer state, per-item decision logic and result register
module nhqpt_core (
   input  logic               clock,
   input  logic               reset,
   input  nhqpt_pkg::csr_type csr,
   input  logic               s1_valid,
   input  nhqpt_pkg::req_type s1_data,
   output logic               s1_take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output nhqpt_pkg::rsp_type rsp_data
);

   logic [nhqpt_pkg::PTR_W-1:0] sub_tail_ff, sub_tail_in;
   logic [nhqpt_pkg::PTR_W-1:0] sub_head_ff, sub_head_in;
   logic [nhqpt_pkg::PTR_W-1:0] comp_head_ff, comp_head_in;
   logic                        phase_ff, phase_in;
   logic                        rsp_valid_ff;
   nhqpt_pkg::rsp_type          rsp_ff, rsp_in;

   logic [nhqpt_pkg::PTR_W-1:0] next_tail;
   logic [nhqpt_pkg::PTR_W-1:0] next_head;
   logic                        sq_full;
   logic                        misaligned;
   logic                        phase_match;

   // item moves into the result register when that register is free
   assign s1_take = s1_valid && (!rsp_valid_ff || rsp_ready);

   // masked pointer increments and checks
   assign next_tail   = (sub_tail_ff + 16'd1) & csr.sq_mask;
   assign next_head   = (comp_head_ff + 16'd1) & csr.cq_mask;
   assign sq_full     = (next_tail == sub_head_ff);
   assign misaligned  = (s1_data.data_addr[nhqpt_pkg::PAGE_BITS-1:0] != '0);
   assign phase_match = (s1_data.entry_status[0] == phase_ff);

   // next state and result
   always_comb begin
      sub_tail_in  = sub_tail_ff;
      sub_head_in  = sub_head_ff;
      comp_head_in = comp_head_ff;
      phase_in     = phase_ff;
      rsp_in       = '0;
      if (s1_data.mode == nhqpt_pkg::MODE_SUBMIT) begin
         rsp_in.kind = nhqpt_pkg::KIND_SUBMIT;
         if (sq_full) begin
            rsp_in.status_code = nhqpt_pkg::ST_FULL;
         end else if (misaligned) begin
            rsp_in.status_code = nhqpt_pkg::ST_MISALIGNED;
         end else begin
            rsp_in.status_code   = nhqpt_pkg::ST_DONE;
            rsp_in.command_word0 = {sub_tail_ff, 8'd0, s1_data.opcode};
            sub_tail_in          = next_tail;
         end
      end else begin
         rsp_in.kind = nhqpt_pkg::KIND_COMPLETE;
         if (!phase_match) begin
            rsp_in.status_code = nhqpt_pkg::ST_NOT_READY;
         end else begin
            rsp_in.status_code = nhqpt_pkg::ST_DONE;
            rsp_in.command_ok  = (s1_data.entry_status[7:1] == 7'd0);
            // phase flips whenever the head wraps round
            if (next_head < comp_head_ff) begin
               phase_in = !phase_ff;
            end
            comp_head_in = next_head;
            sub_head_in  = s1_data.entry_sq_head;
         end
      end
      rsp_in.sq_doorbell  = sub_tail_in;
      rsp_in.cq_doorbell  = comp_head_in;
      rsp_in.cq_slot      = comp_head_in;
      rsp_in.sq_head_seen = sub_head_in;
   end

   // pointer state
   always_ff @(posedge clock) begin
      if (reset) begin
         sub_tail_ff  <= '0;
         sub_head_ff  <= '0;
         comp_head_ff <= '0;
         phase_ff     <= 1'b1;
      end else if (s1_take) begin
         sub_tail_ff  <= sub_tail_in;
         sub_head_ff  <= sub_head_in;
         comp_head_ff <= comp_head_in;
         phase_ff     <= phase_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/nvme_host_queue_pair_tracker.sv =====
// host-side nvme submission/completion queue pair pointer tracker
// path: a request passes the input register, then the result register, before its response is valid
// throughput: one item per cycle while responses are taken; pointers load with the result
// a waiting response blocks the next item, which waits in the input register
// reset (synchronous, active high): tail, heads cleared, expected phase one,
// sq_mask 63, cq_mask 255, both stages empty
module nvme_host_queue_pair_tracker (
   input  logic                             clock,
   input  logic                             reset,
   nhqpt_req_if.sink                        req_chan,
   nhqpt_rsp_if.source                      rsp_chan,
   input  logic                             csr_we,
   input  logic [nhqpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nhqpt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   nhqpt_pkg::csr_type csr;
   nhqpt_pkg::req_type req_data;
   nhqpt_pkg::req_type s1_data;
   nhqpt_pkg::rsp_type rsp_data;
   logic               s1_valid;
   logic               s1_take;
   logic               rsp_valid;

   // request payload into a struct
   assign req_data.mode          = req_chan.mode;
   assign req_data.opcode        = req_chan.opcode;
   assign req_data.data_addr     = req_chan.data_addr;
   assign req_data.entry_status  = req_chan.entry_status;
   assign req_data.entry_sq_head = req_chan.entry_sq_head;

   nhqpt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_out   (csr)
   );

   nhqpt_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_data),
      .out_valid (s1_valid),
      .out_take  (s1_take),
      .out_data  (s1_data)
   );

   nhqpt_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .s1_valid  (s1_valid),
      .s1_data   (s1_data),
      .s1_take   (s1_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_data)
   );

   // response payload out of the struct
   assign rsp_chan.valid         = rsp_valid;
   assign rsp_chan.kind          = rsp_data.kind;
   assign rsp_chan.status_code   = rsp_data.status_code;
   assign rsp_chan.command_word0 = rsp_data.command_word0;
   assign rsp_chan.sq_doorbell   = rsp_data.sq_doorbell;
   assign rsp_chan.cq_doorbell   = rsp_data.cq_doorbell;
   assign rsp_chan.cq_slot       = rsp_data.cq_slot;
   assign rsp_chan.command_ok    = rsp_data.command_ok;
   assign rsp_chan.sq_head_seen  = rsp_data.sq_head_seen;

   // request side stalls only while an item is held in the input register
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid)
      else $error("request stalled with empty input register");

   // a held item moves on as soon as the result register frees up
   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && (!rsp_valid || rsp_chan.ready)) |=> rsp_valid)
      else $error("item lost between input and result register");

   // completion answers never carry a command word
   a_cpl_no_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_chan.kind == nhqpt_pkg::KIND_COMPLETE) |-> rsp_chan.command_word0 == '0)
      else $error("command word on completion answer");

   // command ok only on a consumed completion entry
   a_ok_only_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_chan.command_ok) |->
         (rsp_chan.kind == nhqpt_pkg::KIND_COMPLETE && rsp_chan.status_code == nhqpt_pkg::ST_DONE))
      else $error("command ok without consumed entry");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the nvme queue pair pointer tracker
module tb_top;

   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 6;
   localparam int SHOWN_ERRORS = 10;

   // host-side pointers and masks as the tracker should hold them
   typedef struct {
      logic [nhqpt_pkg::PTR_W-1:0] sq_mask;
      logic [nhqpt_pkg::PTR_W-1:0] cq_mask;
      logic [nhqpt_pkg::PTR_W-1:0] tail;
      logic [nhqpt_pkg::PTR_W-1:0] head;
      logic [nhqpt_pkg::PTR_W-1:0] chead;
      logic                        phase;
   } pair_state_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_we;
   logic [nhqpt_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [nhqpt_pkg::CSR_DATA_W-1:0] csr_wdata;

   nhqpt_req_if req_if ();
   nhqpt_rsp_if rsp_if ();

   nvme_host_queue_pair_tracker u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   nhqpt_pkg::req_type pending_cmds[$];
   nhqpt_pkg::rsp_type expected_answers[$];
   pair_state_type     issue_pair;
   pair_state_type     accept_pair;
   int                 req_gap = 0;
   int                 rsp_stall = 0;
   bit                 req_gaps_on = 1'b1;
   bit                 rsp_stalls_on = 1'b1;
   int                 err_count = 0;
   int                 idle_cycles = 0;

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic pair_state_type fresh_pair();
      pair_state_type s;
      s.sq_mask = nhqpt_pkg::SQ_MASK_RESET;
      s.cq_mask = nhqpt_pkg::CQ_MASK_RESET;
      s.tail    = '0;
      s.head    = '0;
      s.chead   = '0;
      s.phase   = 1'b1;
      return s;
   endfunction

   // one item through the queue pair: updates the pointers, returns the answer
   function automatic nhqpt_pkg::rsp_type advance_queue_pair(inout pair_state_type s,
                                                             input nhqpt_pkg::req_type it);
      nhqpt_pkg::rsp_type          r;
      logic [nhqpt_pkg::PTR_W-1:0] nxt;
      r = '0;
      if (it.mode == nhqpt_pkg::MODE_SUBMIT) begin
         r.kind = nhqpt_pkg::KIND_SUBMIT;
         nxt = (s.tail + 16'd1) & s.sq_mask;
         // full check wins over alignment
         if (nxt == s.head) begin
            r.status_code = nhqpt_pkg::ST_FULL;
         end else if (it.data_addr[nhqpt_pkg::PAGE_BITS-1:0] != '0) begin
            r.status_code = nhqpt_pkg::ST_MISALIGNED;
         end else begin
            r.status_code   = nhqpt_pkg::ST_DONE;
            r.command_word0 = {s.tail, 8'h00, it.opcode};
            s.tail          = nxt;
         end
      end else begin
         r.kind = nhqpt_pkg::KIND_COMPLETE;
         if (it.entry_status[0] != s.phase) begin
            r.status_code = nhqpt_pkg::ST_NOT_READY;
         end else begin
            nxt = (s.chead + 16'd1) & s.cq_mask;
            r.status_code = nhqpt_pkg::ST_DONE;
            r.command_ok  = (it.entry_status[7:1] == '0);
            // phase flips whenever the masked head goes backwards
            if (nxt < s.chead) begin
               s.phase = ~s.phase;
            end
            s.chead = nxt;
            s.head  = it.entry_sq_head;
         end
      end
      r.sq_doorbell  = s.tail;
      r.cq_doorbell  = s.chead;
      r.cq_slot      = s.chead;
      r.sq_head_seen = s.head;
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(4, 24);
      end
   endfunction

   task automatic add_cmd(input logic mode, input logic [nhqpt_pkg::OPC_W-1:0] opc,
                          input logic [nhqpt_pkg::ADDR_W-1:0] addr,
                          input logic [nhqpt_pkg::STAT_W-1:0] stat,
                          input logic [nhqpt_pkg::PTR_W-1:0] sqh);
      nhqpt_pkg::req_type it;
      it.mode          = mode;
      it.opcode        = opc;
      it.data_addr     = addr;
      it.entry_status  = stat;
      it.entry_sq_head = sqh;
      void'(advance_queue_pair(issue_pair, it));
      pending_cmds.push_back(it);
   endtask

   // random item, mostly well formed against the pointers as issued so far
   task automatic add_random_cmd(input int submit_pct);
      logic [nhqpt_pkg::ADDR_W-1:0] addr;
      logic [nhqpt_pkg::STAT_W-1:0] stat;
      logic [nhqpt_pkg::PTR_W-1:0]  in_flight;
      logic [nhqpt_pkg::PTR_W-1:0]  sqh;
      if ($urandom_range(0, 99) < submit_pct) begin
         addr = $urandom();
         if ($urandom_range(0, 99) < 80) begin
            addr[nhqpt_pkg::PAGE_BITS-1:0] = '0;
         end
         add_cmd(nhqpt_pkg::MODE_SUBMIT, 8'($urandom()), addr, 16'($urandom()),
                 16'($urandom()));
      end else begin
         stat = 16'($urandom());
         stat[0] = ($urandom_range(0, 99) < 85) ? issue_pair.phase : ~issue_pair.phase;
         if ($urandom_range(0, 99) < 60) begin
            stat[7:1] = '0;
         end
         // reported sq head somewhere between the current head and the tail
         in_flight = (issue_pair.tail - issue_pair.head) & issue_pair.sq_mask;
         sqh = (issue_pair.head + 16'($urandom_range(0, in_flight))) & issue_pair.sq_mask;
         if ($urandom_range(0, 99) < 8) begin
            sqh = 16'($urandom());
         end
         add_cmd(nhqpt_pkg::MODE_COMPLETE, 8'($urandom()), $urandom(), stat, sqh);
      end
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_if.valid || expected_answers.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [nhqpt_pkg::CSR_IDX_W-1:0] idx,
                            input logic [nhqpt_pkg::PTR_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == nhqpt_pkg::CSR_SQ_MASK) begin
         issue_pair.sq_mask  = val;
         accept_pair.sq_mask = val;
      end else begin
         issue_pair.cq_mask  = val;
         accept_pair.cq_mask = val;
      end
   endtask

   // new masks once the block is idle, with fresh idling choices
   task automatic set_masks(input logic [nhqpt_pkg::PTR_W-1:0] sq,
                            input logic [nhqpt_pkg::PTR_W-1:0] cq);
      wait_drained();
      write_csr(nhqpt_pkg::CSR_SQ_MASK, sq);
      write_csr(nhqpt_pkg::CSR_CQ_MASK, cq);
      @(negedge clock);
      req_gaps_on   = ($urandom_range(0, 3) != 0);
      rsp_stalls_on = ($urandom_range(0, 3) != 0);
   endtask

   task automatic note_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (err_count < SHOWN_ERRORS) begin
         $display("mismatch in %s: expected %0h, got %0h", field, want, got);
      end
      err_count++;
   endtask

   task automatic check_answer(input nhqpt_pkg::rsp_type want,
                               input nhqpt_pkg::rsp_type got);
      if (got.kind != want.kind) note_mismatch("kind", 32'(want.kind), 32'(got.kind));
      if (got.status_code != want.status_code)
         note_mismatch("status_code", 32'(want.status_code), 32'(got.status_code));
      if (got.command_word0 != want.command_word0)
         note_mismatch("command_word0", want.command_word0, got.command_word0);
      if (got.sq_doorbell != want.sq_doorbell)
         note_mismatch("sq_doorbell", 32'(want.sq_doorbell), 32'(got.sq_doorbell));
      if (got.cq_doorbell != want.cq_doorbell)
         note_mismatch("cq_doorbell", 32'(want.cq_doorbell), 32'(got.cq_doorbell));
      if (got.cq_slot != want.cq_slot)
         note_mismatch("cq_slot", 32'(want.cq_slot), 32'(got.cq_slot));
      if (got.command_ok != want.command_ok)
         note_mismatch("command_ok", 32'(want.command_ok), 32'(got.command_ok));
      if (got.sq_head_seen != want.sq_head_seen)
         note_mismatch("sq_head_seen", 32'(want.sq_head_seen), 32'(got.sq_head_seen));
   endtask

   // request driver: holds an item until taken, then idles for a random gap
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap      <= 0;
      end else if (!(req_if.valid && !req_if.ready)) begin
         if (req_if.valid) begin
            expected_answers.push_back(advance_queue_pair(accept_pair, pending_cmds[0]));
            void'(pending_cmds.pop_front());
         end
         if (req_gap > 0) begin
            req_gap      <= req_gap - 1;
            req_if.valid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            req_if.valid         <= 1'b1;
            req_if.mode          <= pending_cmds[0].mode;
            req_if.opcode        <= pending_cmds[0].opcode;
            req_if.data_addr     <= pending_cmds[0].data_addr;
            req_if.entry_status  <= pending_cmds[0].entry_status;
            req_if.entry_sq_head <= pending_cmds[0].entry_sq_head;
            req_gap              <= req_gaps_on ? pick_gap() : 0;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response monitor: checks each item against the oldest expected answer
   always @(posedge clock) begin : rsp_monitor
      nhqpt_pkg::rsp_type got;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.kind          = rsp_if.kind;
            got.status_code   = rsp_if.status_code;
            got.command_word0 = rsp_if.command_word0;
            got.sq_doorbell   = rsp_if.sq_doorbell;
            got.cq_doorbell   = rsp_if.cq_doorbell;
            got.cq_slot       = rsp_if.cq_slot;
            got.command_ok    = rsp_if.command_ok;
            got.sq_head_seen  = rsp_if.sq_head_seen;
            if (expected_answers.size() == 0) begin
               if (err_count < SHOWN_ERRORS) begin
                  $display("unexpected response item: %h", got);
               end
               err_count++;
            end else begin
               check_answer(expected_answers.pop_front(), got);
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall    <= rsp_stall - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (rsp_if.valid && rsp_if.ready) begin
               rsp_stall <= rsp_stalls_on ? pick_gap() : 0;
            end
         end
      end
   end

   // watchdog on cycles in which no request item is accepted
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("** nvme_host_queue_pair_tracker: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      csr_we               = 1'b0;
      csr_index            = nhqpt_pkg::CSR_SQ_MASK;
      csr_wdata            = '0;
      req_if.valid         = 1'b0;
      req_if.mode          = nhqpt_pkg::MODE_SUBMIT;
      req_if.opcode        = '0;
      req_if.data_addr     = '0;
      req_if.entry_status  = '0;
      req_if.entry_sq_head = '0;
      rsp_if.ready         = 1'b0;
      issue_pair           = fresh_pair();
      accept_pair          = fresh_pair();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset masks: opcode and address extremes, each alignment error
      add_cmd(nhqpt_pkg::MODE_SUBMIT, 8'h00, 32'h0000_0000, 16'h0000, 16'h0000);
      add_cmd(nhqpt_pkg::MODE_SUBMIT, 8'hFF, 32'hFFFF_F000, 16'hFFFF, 16'hFFFF);
      add_cmd(nhqpt_pkg::MODE_SUBMIT, 8'hA5, 32'h0000_0001, 16'h0000, 16'h0000);
      add_cmd(nhqpt_pkg::MODE_SUBMIT, 8'h5A, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
      add_cmd(nhqpt_pkg::MODE_SUBMIT, 8'h3C, 32'h0000_0800, 16'h0000, 16'h0000);
      // completions: wrong phase, good and bad status, head out of range
      add_cmd(nhqpt_pkg::MODE_COMPLETE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFE, 16'hFFFF);
      add_cmd(nhqpt_pkg::MODE_COMPLETE, 8'h00, 32'h0000_0000, 16'h0001, 16'h0001);
      add_cmd(nhqpt_pkg::MODE_COMPLETE, 8'h00, 32'h0000_0000, 16'hFF01, 16'h0002);
      add_cmd(nhqpt_pkg::MODE_COMPLETE, 8'h00, 32'h0000_0000, 16'h0003, 16'h0002);
      add_cmd(nhqpt_pkg::MODE_COMPLETE, 8'h00, 32'h0000_0000, 16'h0081, 16'h0002);
      add_cmd(nhqpt_pkg::MODE_COMPLETE, 8'h00, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
      add_cmd(nhqpt_pkg::MODE_SUBMIT, 8'h01, 32'h1234_5000, 16'h0000, 16'h0000);
      add_cmd(nhqpt_pkg::MODE_COMPLETE, 8'h00, 32'h0000_0000, 16'h0001, 16'h0000);

      // smallest queues: head wrap and phase flip, then full beating misaligned
      set_masks(16'd1, 16'd1);
      add_cmd(nhqpt_pkg::MODE_COMPLETE, 8'h00, 32'h0, {15'h0, issue_pair.phase},
              issue_pair.tail & issue_pair.sq_mask);
      add_cmd(nhqpt_pkg::MODE_COMPLETE, 8'h00, 32'h0, {15'h0, ~issue_pair.phase}, 16'h0000);
      add_cmd(nhqpt_pkg::MODE_COMPLETE, 8'h00, 32'h0, {15'h0, issue_pair.phase},
              issue_pair.tail & issue_pair.sq_mask);
      add_cmd(nhqpt_pkg::MODE_COMPLETE, 8'h00, 32'h0, {15'h0, issue_pair.phase},
              issue_pair.tail & issue_pair.sq_mask);
      add_cmd(nhqpt_pkg::MODE_SUBMIT, 8'h11, 32'h0000_1000, 16'h0000, 16'h0000);
      add_cmd(nhqpt_pkg::MODE_SUBMIT, 8'h22, 32'h0000_2000, 16'h0000, 16'h0000);
      add_cmd(nhqpt_pkg::MODE_SUBMIT, 8'h33, 32'h0000_2001, 16'h0000, 16'h0000);
      repeat (70) add_random_cmd(50);

      set_masks(16'd3, 16'd7);
      repeat (80) add_random_cmd(50);

      // widest masks, then shrink so stored pointers sit beyond the mask
      set_masks(16'hFFFF, 16'hFFFF);
      repeat (70) add_random_cmd(60);

      set_masks(16'd7, 16'd3);
      repeat (80) add_random_cmd(50);

      // masks that are not a power of two minus one
      set_masks(16'd5, 16'd10);
      repeat (80) add_random_cmd(50);

      set_masks(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)));
      repeat (70) add_random_cmd(50);

      set_masks(nhqpt_pkg::SQ_MASK_RESET, nhqpt_pkg::CQ_MASK_RESET);
      repeat (100) add_random_cmd(45);

      wait_drained();
      if (err_count == 0) begin
         $display("** nvme_host_queue_pair_tracker: PASSED **");
      end else begin
         $display("** nvme_host_queue_pair_tracker: FAILED **");
      end
      $finish;
   end

endmodule
